// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/ial_pkg.sv =====
// Types and constants of the indexed array list.
package ial_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int VALUE_W    = 32;
  localparam int POS_W      = 5;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int TYPE_W     = 3;

  typedef enum logic [TYPE_W-1:0] {
    REQ_INSERT  = 3'd0,
    REQ_REMOVE  = 3'd1,
    REQ_SELECT  = 3'd2,
    REQ_SEARCH  = 3'd3,
    REQ_REPLACE = 3'd4
  } req_code_t;

  typedef struct packed {
    logic [TYPE_W-1:0]         req_type;
    logic [POS_W-1:0]          position;
    logic signed [VALUE_W-1:0] item_value;
  } req_t;

  typedef struct packed {
    logic                      ok;
    logic signed [VALUE_W-1:0] read_value;
    logic [POS_W-1:0]          found_position;
    logic [CNT_W-1:0]          item_count;
    logic                      is_empty;
    logic                      is_full;
  } rsp_t;

  // Broadcast from the top level to every cell.
  typedef struct packed {
    logic                  do_insert;
    logic                  do_remove;
    logic                  do_replace;
    logic                  rd_en;
    logic [POS_W-1:0]      pos;
    logic [POS_W-1:0]      rd_pos;
    logic [CNT_W-1:0]      count;
    logic [DATA_WIDTH-1:0] value;
  } cell_ctrl_t;

endpackage

// ===== rtl/core/ial_cell.sv =====
// One list slot: holds an entry, shifts with its neighbors, compares and reads.
module ial_cell
  import ial_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  cell_ctrl_t            ctrl,
  input  logic [IDX_W-1:0]      idx,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic [DATA_WIDTH-1:0] right_data,
  output logic [DATA_WIDTH-1:0] data,
  input  logic                  hit_in,
  input  logic [POS_W-1:0]      found_in,
  output logic                  hit_out,
  output logic [POS_W-1:0]      found_out,
  input  logic [DATA_WIDTH-1:0] rd_in,
  output logic [DATA_WIDTH-1:0] rd_out
);

  logic [DATA_WIDTH-1:0] data_next;
  logic [POS_W-1:0]      slot;
  logic                  match;

  assign slot = POS_W'(idx);

  always_comb begin
    data_next = data;
    if (ctrl.do_insert) begin
      if (slot > ctrl.pos) begin
        data_next = left_data;
      end else if (slot == ctrl.pos) begin
        data_next = ctrl.value;
      end
    end else if (ctrl.do_remove) begin
      // slot past the last entry already holds zero, so the top gets cleared
      if (slot >= ctrl.pos) begin
        data_next = right_data;
      end
    end else if (ctrl.do_replace && slot == ctrl.pos) begin
      data_next = ctrl.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      data <= '0;
    end else begin
      data <= data_next;
    end
  end

  // first match wins: pass the earliest hit down the row
  assign match     = (CNT_W'(idx) < ctrl.count) && (data == ctrl.value);
  assign hit_out   = hit_in | match;
  assign found_out = hit_in ? found_in : slot;

  assign rd_out = rd_in | ((ctrl.rd_en && slot == ctrl.rd_pos) ? data : '0);

endmodule

// ===== rtl/core/indexed_array_list_unit.sv =====
// Indexed array list: a row of register cells holding an ordered list of words.
// Each request (insert, remove, select, search, replace) is served by the
// whole row at once: the row shifts, compares and reads in parallel, and the
// result is loaded into the output register at the edge that takes the request.
// A new request is taken every cycle while the result register is empty or
// being transferred, so the rate is one request per cycle; the longest path
// is the search and read chains that run through all sixteen cells. The
// capacity register is written through its own channel, which is always ready.
module indexed_array_list_unit
  import ial_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  req_t             req,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output rsp_t             rsp,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_data
);

  logic [CNT_W-1:0] list_capacity;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W-1:0] cap;
  logic             take;
  logic             full_now;
  logic             ok;
  logic             is_search;
  cell_ctrl_t       ctrl;
  rsp_t             rsp_next;

  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DATA_WIDTH-1:0] left_in   [DEPTH];
  logic [DATA_WIDTH-1:0] right_in  [DEPTH];
  logic                  hit       [DEPTH+1];
  logic [POS_W-1:0]      found     [DEPTH+1];
  logic [DATA_WIDTH-1:0] rd        [DEPTH+1];

  assign cfg_ready = 1'b1;
  assign req_ready = !rsp_valid || rsp_ready;
  assign take      = req_valid && req_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      list_capacity <= CNT_W'(DEPTH);
    end else if (cfg_valid && cfg_ready) begin
      list_capacity <= cfg_data;
    end
  end

  // clamp capacity to 1..DEPTH
  always_comb begin
    if (list_capacity == '0) begin
      cap = CNT_W'(1);
    end else if (list_capacity > CNT_W'(DEPTH)) begin
      cap = CNT_W'(DEPTH);
    end else begin
      cap = list_capacity;
    end
  end

  assign full_now = count >= cap;

  always_comb begin
    ctrl       = '0;
    ctrl.pos   = req.position;
    ctrl.count = count;
    ctrl.value = req.item_value[DATA_WIDTH-1:0];
    ok         = 1'b0;
    is_search  = 1'b0;
    count_next = count;
    case (req_code_t'(req.req_type))
      REQ_INSERT: begin
        if (CNT_W'(req.position) <= count && !full_now && count < CNT_W'(DEPTH)) begin
          ok             = 1'b1;
          ctrl.do_insert = take;
          count_next     = count + CNT_W'(1);
        end
      end
      REQ_REMOVE: begin
        if (CNT_W'(req.position) < count) begin
          ok             = 1'b1;
          ctrl.do_remove = take;
          count_next     = count - CNT_W'(1);
        end
      end
      REQ_SELECT: begin
        ok         = 1'b1;
        ctrl.rd_en = count != '0;
        // past the end: read the last entry
        if (CNT_W'(req.position) < count) begin
          ctrl.rd_pos = req.position;
        end else begin
          ctrl.rd_pos = POS_W'(count - CNT_W'(1));
        end
      end
      REQ_SEARCH: begin
        ok        = 1'b1;
        is_search = 1'b1;
      end
      REQ_REPLACE: begin
        if (CNT_W'(req.position) < count) begin
          ok              = 1'b1;
          ctrl.do_replace = take;
        end
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  assign hit[0]   = 1'b0;
  assign found[0] = '0;
  assign rd[0]    = '0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign left_in[g] = '0;
    end else begin : g_mid
      assign left_in[g] = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_in[g] = '0;
    end else begin : g_inner
      assign right_in[g] = cell_data[g+1];
    end

    ial_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .idx        (IDX_W'(g)),
      .left_data  (left_in[g]),
      .right_data (right_in[g]),
      .data       (cell_data[g]),
      .hit_in     (hit[g]),
      .found_in   (found[g]),
      .hit_out    (hit[g+1]),
      .found_out  (found[g+1]),
      .rd_in      (rd[g]),
      .rd_out     (rd[g+1])
    );
  end

  always_comb begin
    rsp_next            = '0;
    rsp_next.ok         = ok;
    rsp_next.read_value = VALUE_W'(signed'(rd[DEPTH]));
    if (is_search) begin
      rsp_next.found_position = hit[DEPTH] ? found[DEPTH] : POS_W'(count);
    end
    rsp_next.item_count = count_next;
    rsp_next.is_empty   = count_next == '0;
    rsp_next.is_full    = count_next >= cap;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (take) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rsp <= rsp_next;
    end
  end

endmodule

// ===== rtl/core/ial_checker.sv =====
// Port-level checks of the indexed array list, bound to the top level.
`include "assert_macros.svh"

module ial_checker
  import ial_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp
);

  `ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))
  `ASSERT_NEXT(a_req_gives_rsp, req_valid && req_ready, rsp_valid)
  `ASSERT_NOW(a_empty_matches, rsp_valid, rsp.is_empty == (rsp.item_count == '0))
  `ASSERT_NOW(a_refused_quiet, rsp_valid && !rsp.ok, rsp.read_value == '0 && rsp.found_position == '0)
  `ASSERT_NOW(a_count_range, rsp_valid, rsp.item_count <= CNT_W'(DEPTH))

endmodule

bind indexed_array_list_unit ial_checker u_ial_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

// ===== verif/tb_top.sv =====
// Self-checking testbench for the indexed array list unit.
`timescale 1ns / 100ps

module tb_top;
  import ial_pkg::*;

  localparam int CLK_HALF    = 5;
  localparam int RESET_TICKS = 12;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 100;
  localparam int TAIL_CYCLES = 4;

  // Request codes the block does not define
  localparam logic [TYPE_W-1:0] REQ_UNUSED_FIRST = TYPE_W'(REQ_REPLACE + 1);
  localparam logic [TYPE_W-1:0] REQ_UNUSED_LAST  = '1;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} op_mix_t;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             req_valid = 1'b0;
  logic             req_ready;
  req_t             req       = '0;
  logic             rsp_valid;
  logic             rsp_ready = 1'b0;
  rsp_t             rsp;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_data  = '0;

  indexed_array_list_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // Shadow copy of the list
  logic [DATA_WIDTH-1:0] list_words [DEPTH];
  logic [CNT_W-1:0]      list_len;
  logic [CNT_W-1:0]      capacity_setting;

  req_t  pending_requests [$];
  rsp_t  predicted_results [$];
  rsp_t  predicted_now;
  rsp_t  oldest_result;
  int    mismatches = 0;
  int    cycles     = 0;
  int    req_gap    = 0;
  int    rsp_stall  = 0;
  bit    no_idle    = 1'b0;
  logic [VALUE_W-1:0] value_pool [8];

  function automatic int idle_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic req_t make_req(logic [TYPE_W-1:0] code, logic [POS_W-1:0] pos,
                                    logic [VALUE_W-1:0] value);
    req_t r;
    r.req_type   = code;
    r.position   = pos;
    r.item_value = value;
    return r;
  endfunction

  task automatic apply_list_request(input req_t r, output rsp_t res);
    int cap;
    int at;
    cap = capacity_setting;
    if (cap < 1) cap = 1;
    if (cap > DEPTH) cap = DEPTH;
    res = '0;
    case (r.req_type)
      REQ_INSERT: begin
        if (r.position <= list_len && list_len < cap && list_len < DEPTH) begin
          for (int i = list_len; i > r.position; i--) list_words[i] = list_words[i-1];
          list_words[r.position] = r.item_value[DATA_WIDTH-1:0];
          list_len++;
          res.ok = 1'b1;
        end
      end
      REQ_REMOVE: begin
        if (r.position < list_len) begin
          for (int i = r.position; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
          list_words[list_len-1] = '0;
          list_len--;
          res.ok = 1'b1;
        end
      end
      REQ_SELECT: begin
        res.ok = 1'b1;
        if (list_len > 0) begin
          // past the end, read the last entry
          at = (r.position < list_len) ? r.position : list_len - 1;
          res.read_value = list_words[at];
        end
      end
      REQ_SEARCH: begin
        res.ok = 1'b1;
        res.found_position = list_len;
        for (int i = list_len - 1; i >= 0; i--)
          if (list_words[i] == r.item_value[DATA_WIDTH-1:0]) res.found_position = POS_W'(i);
      end
      REQ_REPLACE: begin
        if (r.position < list_len) begin
          list_words[r.position] = r.item_value[DATA_WIDTH-1:0];
          res.ok = 1'b1;
        end
      end
      default: ;
    endcase
    res.item_count = list_len;
    res.is_empty   = (list_len == 0);
    res.is_full    = (list_len >= cap);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Request driver; also tracks the shadow list on every transfer
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      list_len = '0;
      capacity_setting = CNT_W'(DEPTH);
      foreach (list_words[i]) list_words[i] = '0;
    end else begin
      if (cfg_valid && cfg_ready) capacity_setting = cfg_data;
      if (req_valid && req_ready) begin
        apply_list_request(req, predicted_now);
        predicted_results.push_back(predicted_now);
      end
      if (!req_valid || req_ready) begin
        if (req_gap > 0) begin
          req_gap--;
          req_valid <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          req       <= pending_requests.pop_front();
          req_valid <= 1'b1;
          req_gap = idle_len();
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (predicted_results.size() == 0) begin
          $display("%0t: result with nothing expected, actual %0h", $time, rsp);
          mismatches++;
        end else begin
          oldest_result = predicted_results.pop_front();
          check_field("ok", rsp.ok, oldest_result.ok);
          check_field("read_value", rsp.read_value, oldest_result.read_value);
          check_field("found_position", rsp.found_position, oldest_result.found_position);
          check_field("item_count", rsp.item_count, oldest_result.item_count);
          check_field("is_empty", rsp.is_empty, oldest_result.is_empty);
          check_field("is_full", rsp.is_full, oldest_result.is_full);
        end
      end
      if (rsp_stall > 0) begin
        rsp_stall--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
        rsp_stall = idle_len();
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL indexed_array_list_unit");
      $finish;
    end
  end

  // Hold until every queued request is sent and every result has come back
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_requests.size() != 0 || req_valid || predicted_results.size() != 0);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CNT_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_random_items(input op_mix_t mix, input int n);
    int w_ins;
    int w_rem;
    int r;
    logic [TYPE_W-1:0]  code;
    logic [POS_W-1:0]   pos;
    logic [VALUE_W-1:0] value;
    case (mix)
      MIX_FILL:  begin w_ins = 55; w_rem = 10; end
      MIX_DRAIN: begin w_ins = 12; w_rem = 50; end
      default:   begin w_ins = 30; w_rem = 28; end
    endcase
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < w_ins) code = REQ_INSERT;
      else if (r < w_ins + w_rem) code = REQ_REMOVE;
      else if (r < 97) begin
        case ($urandom_range(0, 2))
          0:       code = REQ_SELECT;
          1:       code = REQ_SEARCH;
          default: code = REQ_REPLACE;
        endcase
      end else code = TYPE_W'($urandom_range(REQ_UNUSED_FIRST, REQ_UNUSED_LAST));
      pos   = POS_W'(($urandom_range(0, 99) < 85) ? $urandom_range(0, DEPTH + 1)
                                                  : $urandom());
      // draw from a small pool often so that searches hit
      value = ($urandom_range(0, 1) == 0) ? value_pool[$urandom_range(0, 7)] : $urandom();
      pending_requests.push_back(make_req(code, pos, value));
    end
  endtask

  initial begin
    logic [CNT_W-1:0] cap_plan [11];
    op_mix_t          mix_plan [11];
    cap_plan = '{5'd2, 5'd0, 5'd31, 5'd16, 5'd1, 5'd17, 5'd5, 5'd9, 5'd16, 5'd3, 5'd12};
    mix_plan = '{MIX_EVEN, MIX_EVEN, MIX_FILL, MIX_DRAIN, MIX_FILL, MIX_FILL,
                 MIX_EVEN, MIX_DRAIN, MIX_FILL, MIX_EVEN, MIX_DRAIN};
    value_pool = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                   $urandom(), $urandom(), $urandom(), $urandom()};

    // empty list: reads, refusals, then build and edit a short list
    pending_requests.push_back(make_req(REQ_SELECT, 0, 0));
    pending_requests.push_back(make_req(REQ_SEARCH, 0, 5));
    pending_requests.push_back(make_req(REQ_REMOVE, 0, 0));
    pending_requests.push_back(make_req(REQ_REPLACE, 0, 7));
    pending_requests.push_back(make_req(REQ_INSERT, 1, 3));
    pending_requests.push_back(make_req(REQ_INSERT, 0, 32'h7FFF_FFFF));
    pending_requests.push_back(make_req(REQ_INSERT, 0, 32'h8000_0000));
    pending_requests.push_back(make_req(REQ_INSERT, 2, 32'hFFFF_FFFF));
    pending_requests.push_back(make_req(REQ_INSERT, 1, 32'h0));
    pending_requests.push_back(make_req(REQ_SELECT, 0, 0));
    pending_requests.push_back(make_req(REQ_SELECT, 31, 0));
    pending_requests.push_back(make_req(REQ_SELECT, 16, 0));
    pending_requests.push_back(make_req(REQ_SEARCH, 0, 32'hFFFF_FFFF));
    pending_requests.push_back(make_req(REQ_SEARCH, 0, 32'h0001_2345));
    pending_requests.push_back(make_req(REQ_REPLACE, 3, 32'h5A5A_5A5A));
    pending_requests.push_back(make_req(REQ_REPLACE, 4, 32'h1));
    pending_requests.push_back(make_req(REQ_SEARCH, 31, 32'h0));
    pending_requests.push_back(make_req(REQ_REMOVE, 1, 0));
    pending_requests.push_back(make_req(REQ_REMOVE, 31, 0));
    pending_requests.push_back(make_req(REQ_UNUSED_FIRST, 0, 0));
    pending_requests.push_back(make_req(REQ_UNUSED_LAST, 31, 32'hFFFF_FFFF));
    pending_requests.push_back(make_req(REQ_REMOVE, 2, 0));
    pending_requests.push_back(make_req(REQ_INSERT, 2, 32'h1));

    repeat (RESET_TICKS) @(posedge clk);
    rst <= 1'b0;
    wait_drained();

    // first setting lands below the current count
    foreach (cap_plan[p]) begin
      no_idle = (p % 4 == 1);
      write_capacity(cap_plan[p]);
      add_random_items(mix_plan[p], PHASE_ITEMS);
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && predicted_results.size() == 0)
      $display("PASS indexed_array_list_unit");
    else
      $display("FAIL indexed_array_list_unit");
    $finish;
  end

endmodule
